// ----- hw/rtl/tot_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, codes and control structs of the 2-opt tour improver
// no dependencies
package tot_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int MIN_SPAN   = 3;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PT_W       = 2 * COORD_BITS;
  localparam int SQ_W       = 2 * COORD_BITS + 1;
  localparam int ROOT_W     = COORD_BITS + 1;
  localparam int SUM_W      = ROOT_W + 1;
  localparam int LIMIT_W    = 8;
  localparam int SWAP_W     = 16;
  localparam logic [LIMIT_W-1:0] PASS_LIMIT_RESET = 8'd255;
  localparam logic [SWAP_W-1:0]  SWAP_MAX         = {SWAP_W{1'b1}};

  typedef enum logic [4:0] {
    ST_LOAD, ST_TOUR_INIT, ST_PASS_INIT, ST_S_CHECK, ST_J_INIT,
    ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_D, ST_CAP_D,
    ST_DIST_GO, ST_DIST_WAIT, ST_CMP,
    ST_REV_INIT, ST_REV_CHECK, ST_REV_RL, ST_REV_RH, ST_REV_CAP, ST_REV_WL, ST_REV_WH,
    ST_J_NEXT, ST_S_NEXT, ST_PASS_END,
    ST_EMIT_INIT, ST_EM_RD, ST_EM_LOAD, ST_EM_WAIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_STORE, OP_TOUR_INIT, OP_PASS_INIT, OP_J_INIT, OP_J_INC, OP_S_INC,
    OP_REV_INIT, OP_REV_STEP, OP_PASS_INC, OP_K_CLEAR, OP_K_INC, OP_TOUR_DONE
  } dp_op_t;

  typedef enum logic [2:0] {
    RD_S, RD_S1, RD_JM1, RD_J, RD_LO, RD_HI, RD_K
  } rd_sel_t;

  typedef enum logic [1:0] {
    CAP_A, CAP_B, CAP_C, CAP_D
  } cap_sel_t;

  typedef enum logic [1:0] {
    WR_IN, WR_LO, WR_HI
  } wr_sel_t;

  typedef struct packed {
    dp_op_t     op;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       cap_en;
    cap_sel_t   cap_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       dist_start;
    logic [1:0] dist_pair;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic count_last;
    logic s_ok;
    logic j_last;
    logic improve;
    logic lo_lt_hi;
    logic more_passes;
    logic k_last;
    logic dist_done;
  } dp_status_t;

endpackage

// ----- hw/rtl/tot_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for points in and tour points out
// depends on tot_pkg
interface tot_in_if;
  import tot_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  logic                  last_point;
  modport source (output valid, coord_x, coord_y, last_point, input ready);
  modport sink (input valid, coord_x, coord_y, last_point, output ready);
endinterface

interface tot_out_if;
  import tot_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  end_of_tour;
  logic [SWAP_W-1:0]     swap_total;
  logic                  converged;
  modport source (output valid, out_x, out_y, end_of_tour, swap_total, converged,
                  input ready);
  modport sink (input valid, out_x, out_y, end_of_tour, swap_total, converged,
                output ready);
endinterface

// ----- hw/rtl/two_opt_tour_improver.sv -----
`timescale 1ns / 1ps
// top level of the 2-opt tour improver: controller plus datapath
// depends on tot_pkg, tot_if, tot_ctrl, tot_dp
//
//   channel    | dir | carries
//   points     | in  | coord_x, coord_y, last_point
//   tour       | out | out_x, out_y, end_of_tour, swap_total, converged
//   pass_limit | in  | pass_limit_we, pass_limit_data (write only)
//
// points load one per cycle; the last point (or the 64th) starts optimization
// each j test does four reads, then four distances through the shared
// bit-serial square root (17 iterations each)
// a reversal reads, captures and writes back each swapped pair; emission reads, loads and offers each point
// synchronous reset returns to loading; tour output stalls hold the result register
module two_opt_tour_improver (
  input  logic                       clk,
  input  logic                       rst,
  tot_in_if.sink                     points,
  tot_out_if.source                  tour,
  input  logic                       pass_limit_we,
  input  logic [tot_pkg::LIMIT_W-1:0] pass_limit_data
);
  import tot_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_last   (points.last_point),
    .out_ready (tour.ready),
    .status    (status),
    .in_ready  (points.ready),
    .out_valid (tour.valid),
    .cmd       (cmd)
  );

  tot_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_x       (points.coord_x),
    .in_y       (points.coord_y),
    .cfg_we     (pass_limit_we),
    .cfg_data   (pass_limit_data),
    .cmd        (cmd),
    .status     (status),
    .out_x      (tour.out_x),
    .out_y      (tour.out_y),
    .out_end    (tour.end_of_tour),
    .swap_total (tour.swap_total),
    .converged  (tour.converged)
  );

endmodule

// ----- hw/rtl/tot_isqrt.sv -----
`timescale 1ns / 1ps
// iterative integer square root, one result bit per cycle
// depends on tot_pkg
module tot_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tot_pkg::SQ_W-1:0]  value,
  output logic                      done,
  output logic [tot_pkg::ROOT_W-1:0] root
);
  import tot_pkg::*;

  localparam int RW    = SQ_W + 1;
  localparam int ITERS = COORD_BITS + 1;
  localparam int IT_W  = $clog2(ITERS + 1);

  logic [RW-1:0]   v;
  logic [RW-1:0]   r;
  logic [RW-1:0]   bitv;
  logic [IT_W-1:0] iter;
  logic            busy;
  logic [RW-1:0]   trial;

  assign trial = r + bitv;
  assign root  = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && iter == IT_W'(ITERS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= RW'(value);
      r    <= '0;
      bitv <= RW'(1) << (2 * COORD_BITS);
      iter <= '0;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
      iter <= iter + IT_W'(1);
    end
  end

endmodule

// ----- hw/rtl/tot_dp.sv -----
`timescale 1ns / 1ps
// datapath: point memory, loop indexes, distance pipeline, counters, output register
// depends on tot_pkg and tot_isqrt
module tot_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tot_pkg::COORD_BITS-1:0] in_x,
  input  logic [tot_pkg::COORD_BITS-1:0] in_y,
  input  logic                          cfg_we,
  input  logic [tot_pkg::LIMIT_W-1:0]   cfg_data,
  input  tot_pkg::dp_cmd_t              cmd,
  output tot_pkg::dp_status_t           status,
  output logic [tot_pkg::COORD_BITS-1:0] out_x,
  output logic [tot_pkg::COORD_BITS-1:0] out_y,
  output logic                          out_end,
  output logic [tot_pkg::SWAP_W-1:0]    swap_total,
  output logic                          converged
);
  import tot_pkg::*;

  logic [PT_W-1:0]    pt_mem [MAX_POINTS];
  logic [PT_W-1:0]    rdata;
  logic [PT_W-1:0]    pa, pb, pc, pd;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [PT_W-1:0]    wdata;

  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  s, j, lo, hi, k;
  logic [SWAP_W-1:0]  swap_cnt;
  logic [LIMIT_W-1:0] pass_cnt;
  logic               pass_swapped;
  logic [LIMIT_W-1:0] pass_limit;
  logic [LIMIT_W-1:0] eff_limit;

  logic [PT_W-1:0]       op1, op2;
  logic [COORD_BITS-1:0] dx, dy;
  logic [PT_W-1:0]       sqx, sqy;
  logic                  v1, v2;
  logic [1:0]            pair_q;
  logic                  sq_done;
  logic [ROOT_W-1:0]     root;
  logic [SUM_W-1:0]      now_len, alt_len;

  always_comb begin
    case (cmd.rd_sel)
      RD_S:    rd_addr = s;
      RD_S1:   rd_addr = s + ADDR_W'(1);
      RD_JM1:  rd_addr = j - ADDR_W'(1);
      RD_J:    rd_addr = j;
      RD_LO:   rd_addr = lo;
      RD_HI:   rd_addr = hi;
      RD_K:    rd_addr = k;
      default: rd_addr = k;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_IN: begin
        wr_addr = count[ADDR_W-1:0];
        wdata   = {in_x, in_y};
      end
      WR_LO: begin
        wr_addr = lo;
        wdata   = pb;
      end
      WR_HI: begin
        wr_addr = hi;
        wdata   = pa;
      end
      default: begin
        wr_addr = hi;
        wdata   = pa;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) pt_mem[wr_addr] <= wdata;
    if (cmd.rd_en) rdata <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        CAP_A:   pa <= rdata;
        CAP_B:   pb <= rdata;
        CAP_C:   pc <= rdata;
        CAP_D:   pd <= rdata;
        default: pd <= rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      swap_cnt     <= '0;
      pass_cnt     <= '0;
      pass_swapped <= 1'b0;
      pass_limit   <= PASS_LIMIT_RESET;
    end else begin
      if (cfg_we) pass_limit <= cfg_data;
      case (cmd.op)
        OP_STORE: count <= count + CNT_W'(1);
        OP_TOUR_INIT: begin
          swap_cnt <= '0;
          pass_cnt <= '0;
        end
        OP_PASS_INIT: pass_swapped <= 1'b0;
        OP_REV_INIT: begin
          pass_swapped <= 1'b1;
          if (swap_cnt != SWAP_MAX) swap_cnt <= swap_cnt + SWAP_W'(1);
        end
        OP_PASS_INC: pass_cnt <= pass_cnt + LIMIT_W'(1);
        OP_TOUR_DONE: begin
          count        <= '0;
          swap_cnt     <= '0;
          pass_cnt     <= '0;
          pass_swapped <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PASS_INIT: s <= '0;
      OP_S_INC:     s <= s + ADDR_W'(1);
      OP_J_INIT:    j <= s + ADDR_W'(MIN_SPAN);
      OP_J_INC:     j <= j + ADDR_W'(1);
      OP_REV_INIT: begin
        lo <= s + ADDR_W'(1);
        hi <= j - ADDR_W'(1);
      end
      OP_REV_STEP: begin
        lo <= lo + ADDR_W'(1);
        hi <= hi - ADDR_W'(1);
      end
      OP_K_CLEAR:   k <= '0;
      OP_K_INC:     k <= k + ADDR_W'(1);
      default: ;
    endcase
  end

  // edge pairs: current (s,s+1) and (j-1,j), then candidates (s,j-1) and (s+1,j)
  always_comb begin
    case (cmd.dist_pair)
      2'd0:    begin op1 = pa; op2 = pb; end
      2'd1:    begin op1 = pc; op2 = pd; end
      2'd2:    begin op1 = pa; op2 = pc; end
      default: begin op1 = pb; op2 = pd; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.dist_start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_start) begin
      pair_q <= cmd.dist_pair;
      dx <= (op1[PT_W-1:COORD_BITS] > op2[PT_W-1:COORD_BITS])
          ? op1[PT_W-1:COORD_BITS] - op2[PT_W-1:COORD_BITS]
          : op2[PT_W-1:COORD_BITS] - op1[PT_W-1:COORD_BITS];
      dy <= (op1[COORD_BITS-1:0] > op2[COORD_BITS-1:0])
          ? op1[COORD_BITS-1:0] - op2[COORD_BITS-1:0]
          : op2[COORD_BITS-1:0] - op1[COORD_BITS-1:0];
    end
    if (v1) begin
      sqx <= PT_W'(dx) * PT_W'(dx);
      sqy <= PT_W'(dy) * PT_W'(dy);
    end
  end

  tot_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (v2),
    .value (SQ_W'(sqx) + SQ_W'(sqy)),
    .done  (sq_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (sq_done) begin
      case (pair_q)
        2'd0:    now_len <= SUM_W'(root);
        2'd1:    now_len <= now_len + SUM_W'(root);
        2'd2:    alt_len <= SUM_W'(root);
        default: alt_len <= alt_len + SUM_W'(root);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x   <= rdata[PT_W-1:COORD_BITS];
      out_y   <= rdata[COORD_BITS-1:0];
      out_end <= status.k_last;
    end
  end

  assign eff_limit = (pass_limit == '0) ? LIMIT_W'(1) : pass_limit;

  always_comb begin
    status.count_last  = count == CNT_W'(MAX_POINTS - 1);
    status.s_ok        = (CNT_W'(s) + CNT_W'(MIN_SPAN)) < count;
    status.j_last      = (CNT_W'(j) + CNT_W'(1)) == count;
    status.k_last      = (CNT_W'(k) + CNT_W'(1)) == count;
    status.improve     = now_len > alt_len;
    status.lo_lt_hi    = lo < hi;
    status.more_passes = pass_swapped &&
                         (({1'b0, pass_cnt} + (LIMIT_W + 1)'(1)) < {1'b0, eff_limit});
    status.dist_done   = sq_done;
  end

  assign swap_total = swap_cnt;
  assign converged  = !pass_swapped;

endmodule

// ----- hw/rtl/tot_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences loading, 2-opt passes, segment reversal and emission
// depends on tot_pkg
module tot_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  input  logic                out_ready,
  input  tot_pkg::dp_status_t status,
  output logic                in_ready,
  output logic                out_valid,
  output tot_pkg::dp_cmd_t    cmd
);
  import tot_pkg::*;

  ctrl_state_t state, state_next;
  logic [1:0]  pair, pair_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      pair  <= '0;
    end else begin
      state <= state_next;
      pair  <= pair_next;
    end
  end

  always_comb begin
    state_next     = state;
    pair_next      = pair;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.op         = OP_NONE;
    cmd.rd_sel     = RD_K;
    cmd.cap_sel    = CAP_A;
    cmd.wr_sel     = WR_IN;
    cmd.dist_pair  = pair;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_STORE;
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_IN;
          if (in_last || status.count_last) state_next = ST_TOUR_INIT;
        end
      end
      ST_TOUR_INIT: begin
        cmd.op     = OP_TOUR_INIT;
        state_next = ST_PASS_INIT;
      end
      ST_PASS_INIT: begin
        cmd.op     = OP_PASS_INIT;
        state_next = ST_S_CHECK;
      end
      ST_S_CHECK: state_next = status.s_ok ? ST_J_INIT : ST_PASS_END;
      ST_J_INIT: begin
        cmd.op     = OP_J_INIT;
        state_next = ST_RD_A;
      end
      // memory read data is registered and lands in the cycle after the address
      ST_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_S;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_S1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_A;
        state_next  = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_JM1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_B;
        state_next  = ST_RD_D;
      end
      ST_RD_D: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_J;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_C;
        state_next  = ST_CAP_D;
      end
      ST_CAP_D: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_D;
        pair_next   = '0;
        state_next  = ST_DIST_GO;
      end
      ST_DIST_GO: begin
        cmd.dist_start = 1'b1;
        state_next     = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: begin
        if (status.dist_done) begin
          if (pair == 2'd3) begin
            state_next = ST_CMP;
          end else begin
            pair_next  = pair + 2'd1;
            state_next = ST_DIST_GO;
          end
        end
      end
      ST_CMP: state_next = status.improve ? ST_REV_INIT : ST_J_NEXT;
      ST_REV_INIT: begin
        cmd.op     = OP_REV_INIT;
        state_next = ST_REV_CHECK;
      end
      ST_REV_CHECK: state_next = status.lo_lt_hi ? ST_REV_RL : ST_J_NEXT;
      ST_REV_RL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LO;
        state_next = ST_REV_RH;
      end
      ST_REV_RH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_HI;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_A;
        state_next  = ST_REV_CAP;
      end
      ST_REV_CAP: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_B;
        state_next  = ST_REV_WL;
      end
      ST_REV_WL: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_LO;
        state_next = ST_REV_WH;
      end
      ST_REV_WH: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_HI;
        cmd.op     = OP_REV_STEP;
        state_next = ST_REV_CHECK;
      end
      ST_J_NEXT: begin
        if (status.j_last) begin
          state_next = ST_S_NEXT;
        end else begin
          cmd.op     = OP_J_INC;
          state_next = ST_RD_A;
        end
      end
      ST_S_NEXT: begin
        cmd.op     = OP_S_INC;
        state_next = ST_S_CHECK;
      end
      ST_PASS_END: begin
        cmd.op     = OP_PASS_INC;
        state_next = status.more_passes ? ST_PASS_INIT : ST_EMIT_INIT;
      end
      ST_EMIT_INIT: begin
        cmd.op     = OP_K_CLEAR;
        state_next = ST_EM_RD;
      end
      ST_EM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_K;
        state_next = ST_EM_LOAD;
      end
      ST_EM_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.k_last) begin
            cmd.op     = OP_TOUR_DONE;
            state_next = ST_LOAD;
          end else begin
            cmd.op     = OP_K_INC;
            state_next = ST_EM_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

// ----- hw/rtl/tot_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the 2-opt tour improver, bound to the top level
// depends on tot_pkg and two_opt_tour_improver
module tot_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_end,
  input logic [tot_pkg::COORD_BITS-1:0] out_x,
  input logic [tot_pkg::COORD_BITS-1:0] out_y
);
  import tot_pkg::*;

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a tour point is offered");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("stalled tour point changed");

  a_tour_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_end |=> !out_valid && in_ready)
    else $error("block not back to loading after the tour end");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still taken after the closing point");

endmodule

bind two_opt_tour_improver tot_checker u_tot_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (points.valid),
  .in_ready  (points.ready),
  .in_last   (points.last_point),
  .out_valid (tour.valid),
  .out_ready (tour.ready),
  .out_end   (tour.end_of_tour),
  .out_x     (tour.out_x),
  .out_y     (tour.out_y)
);
